>>> hw/rtl/sphere_box_overlap_test_defines.svh
// assertion macros for the overlap tester
`ifndef SPHERE_BOX_OVERLAP_TEST_DEFINES_SVH
`define SPHERE_BOX_OVERLAP_TEST_DEFINES_SVH

// consequent checked on the next clock
`define SBOT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// consequent checked on the same clock
`define SBOT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/sbot_pkg.sv
`default_nettype none

package sbot_pkg;

   localparam int POS_W    = 32;
   localparam int SIZE_W   = 32;
   localparam int RAD_W    = 32;
   localparam int SCALE_W  = 16;
   localparam int AXES     = 3;

   localparam int MUL_W    = POS_W + 2;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int ERAD_W   = RAD_W + SCALE_W + 1;
   localparam int SPLIT_W  = 25;
   localparam int HI_W     = ERAD_W - SPLIT_W;
   localparam int RSQ_W    = 2 * ERAD_W;
   localparam int DIST_W   = PROD_W + 2;
   localparam int DIST_SH  = 14;
   localparam int SUM_W    = SIZE_W + 1;
   localparam int DIFF_W   = MUL_W + 1;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_TEST    = 1'b1;
   localparam logic KIND_SPHERE = 1'b0;
   localparam logic KIND_BOX    = 1'b1;

   typedef struct packed {
      logic                      cmd;
      logic                      kind;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic signed [POS_W-1:0]   pos_z;
      logic [SIZE_W-1:0]         size_x;
      logic [SIZE_W-1:0]         size_y;
      logic [SIZE_W-1:0]         size_z;
      logic [RAD_W-1:0]          radius;
      logic [SCALE_W-1:0]        scale_x;
      logic [SCALE_W-1:0]        scale_y;
      logic [SCALE_W-1:0]        scale_z;
   } sbot_req_type;

   typedef struct packed {
      logic hit;
   } sbot_rsp_type;

   typedef struct packed {
      logic                           kind;
      logic [AXES-1:0][POS_W-1:0]     pos;
      logic [AXES-1:0][SIZE_W-1:0]    size;
      logic [RAD_W-1:0]               radius;
      logic [AXES-1:0][SCALE_W-1:0]   scale;
   } sbot_shape_type;

   typedef struct packed {
      logic [1:0] tgt;
      logic [1:0] sh;
   } sbot_tag_type;

   function automatic sbot_shape_type to_shape(sbot_req_type r);
      sbot_shape_type s;
      s.kind     = r.kind;
      s.pos[0]   = r.pos_x;
      s.pos[1]   = r.pos_y;
      s.pos[2]   = r.pos_z;
      s.size[0]  = r.size_x;
      s.size[1]  = r.size_y;
      s.size[2]  = r.size_z;
      s.radius   = r.radius;
      s.scale[0] = r.scale_x;
      s.scale[1] = r.scale_y;
      s.scale[2] = r.scale_z;
      return s;
   endfunction

   function automatic logic [SCALE_W-1:0] max_scale(logic [AXES-1:0][SCALE_W-1:0] sc);
      logic [SCALE_W-1:0] m;
      m = sc[0];
      if (sc[1] > m) begin
         m = sc[1];
      end
      if (sc[2] > m) begin
         m = sc[2];
      end
      return m;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sbot_channels.sv
`default_nettype none

interface sbot_req_if import sbot_pkg::*; ();
   logic         valid;
   logic         ready;
   sbot_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface sbot_rsp_if import sbot_pkg::*; ();
   logic         valid;
   logic         ready;
   sbot_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sphere_box_overlap_test.sv
// Sphere / axis-aligned box overlap tester. A load transaction (cmd 0) stores its shape as
// the reference and returns nothing; a test transaction (cmd 1) returns one hit flag. While a
// test works through its steps to the result register, req_ch.ready stays low, so neither a
// load nor another test is accepted until that test is done. One 34x34 multiplier,
// registered and followed by one shared shift-add accumulator, works through eight products
// in turn (two effective radii, three partial products of the squared radius sum, one squared
// gap per axis), then the distance is compared with the squared radius. Box-box tests use the
// same per-axis gap unit and ignore the products. Positions are signed Q16.16, sizes and
// radius unsigned Q16.16, scales unsigned Q8.8; all arithmetic is exact. A waiting result
// does not stop loads or the start of the next test; a finished test holds only while the
// result register is full.

`default_nettype none

`include "sphere_box_overlap_test_defines.svh"

module sphere_box_overlap_test import sbot_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   sbot_req_if.sink    req_ch,
   sbot_rsp_if.source  rsp_ch
);

   localparam logic [3:0] STEP_REF_RAD = 4'd0;
   localparam logic [3:0] STEP_TST_RAD = 4'd1;
   localparam logic [3:0] STEP_AXIS_X  = 4'd2;
   localparam logic [3:0] STEP_RSQ_LO  = 4'd3;
   localparam logic [3:0] STEP_RSQ_MID = 4'd4;
   localparam logic [3:0] STEP_RSQ_HI  = 4'd5;
   localparam logic [3:0] STEP_AXIS_Y  = 4'd6;
   localparam logic [3:0] STEP_AXIS_Z  = 4'd7;
   localparam logic [3:0] STEP_FLUSH   = 4'd8;
   localparam logic [3:0] STEP_DONE    = 4'd9;

   localparam logic [1:0] TGT_NONE = 2'd0;
   localparam logic [1:0] TGT_RAD  = 2'd1;
   localparam logic [1:0] TGT_RSQ  = 2'd2;
   localparam logic [1:0] TGT_DIST = 2'd3;

   localparam logic [1:0] SH_NONE = 2'd0;
   localparam logic [1:0] SH_MID  = 2'd1;
   localparam logic [1:0] SH_HIGH = 2'd2;

   localparam int MID_SH  = SPLIT_W + 1;
   localparam int HIGH_SH = 2 * SPLIT_W;

   sbot_shape_type      ref_ff, ref_in;
   sbot_shape_type      tst_ff, tst_in;
   logic                busy_ff, busy_in;
   logic [3:0]          step_ff, step_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   sbot_tag_type        tag_ff, tag_in;
   logic [ERAD_W-1:0]   rad_ff, rad_in;
   logic [RSQ_W-1:0]    rsq_ff, rsq_in;
   logic [DIST_W-1:0]   dist_ff, dist_in;
   logic                bb_ff, bb_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;

   logic                req_accept;
   logic                rsp_free;
   sbot_shape_type      rad_shape;
   logic [SCALE_W-1:0]  scale_max;
   logic [1:0]          axis;
   logic signed [POS_W:0] pos_diff;
   logic [POS_W:0]      pos_mag;
   logic [SUM_W-1:0]    size_sum;
   logic signed [DIFF_W-1:0] gap;
   logic                gap_neg;
   logic [MUL_W-1:0]    gap_mag;
   logic [MUL_W-1:0]    mul_a, mul_b;
   logic [RSQ_W-1:0]    addend, add_base, add_sum;
   logic [RSQ_W-1:0]    dist_scaled;
   logic                both_box;
   logic                hit;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !busy_ff;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.payload.hit = rsp_hit_ff;

   // per-axis gap, in doubled units: 2|pa - pb| - box sizes
   always_comb begin
      unique case (step_ff)
         STEP_AXIS_X: axis = 2'd0;
         STEP_AXIS_Y: axis = 2'd1;
         default:     axis = 2'd2;
      endcase
   end

   assign pos_diff = $signed({ref_ff.pos[axis][POS_W-1], ref_ff.pos[axis]})
                   - $signed({tst_ff.pos[axis][POS_W-1], tst_ff.pos[axis]});
   assign pos_mag = pos_diff[POS_W] ? '0 - pos_diff : pos_diff;
   assign size_sum = ((ref_ff.kind == KIND_BOX) ? {1'b0, ref_ff.size[axis]} : '0)
                   + ((tst_ff.kind == KIND_BOX) ? {1'b0, tst_ff.size[axis]} : '0);
   assign gap = $signed({1'b0, pos_mag, 1'b0}) - $signed({2'b00, size_sum});
   assign gap_neg = gap[DIFF_W-1];
   assign gap_mag = gap_neg ? '0 : gap[MUL_W-1:0];

   assign rad_shape = (step_ff == STEP_REF_RAD) ? ref_ff : tst_ff;
   assign scale_max = max_scale(rad_shape.scale);

   // operand issue for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      tag_in.tgt = TGT_NONE;
      tag_in.sh = SH_NONE;
      if (busy_ff) begin
         unique case (step_ff)
            STEP_REF_RAD, STEP_TST_RAD: begin
               mul_a = MUL_W'(rad_shape.radius);
               mul_b = MUL_W'(scale_max);
               tag_in.tgt = (rad_shape.kind == KIND_SPHERE) ? TGT_RAD : TGT_NONE;
            end
            STEP_AXIS_X, STEP_AXIS_Y, STEP_AXIS_Z: begin
               mul_a = gap_mag;
               mul_b = gap_mag;
               tag_in.tgt = TGT_DIST;
            end
            STEP_RSQ_LO: begin
               mul_a = MUL_W'(rad_ff[SPLIT_W-1:0]);
               mul_b = MUL_W'(rad_ff[SPLIT_W-1:0]);
               tag_in.tgt = TGT_RSQ;
            end
            STEP_RSQ_MID: begin
               mul_a = MUL_W'(rad_ff[ERAD_W-1:SPLIT_W]);
               mul_b = MUL_W'(rad_ff[SPLIT_W-1:0]);
               tag_in.tgt = TGT_RSQ;
               tag_in.sh = SH_MID;
            end
            STEP_RSQ_HI: begin
               mul_a = MUL_W'(rad_ff[ERAD_W-1:SPLIT_W]);
               mul_b = MUL_W'(rad_ff[ERAD_W-1:SPLIT_W]);
               tag_in.tgt = TGT_RSQ;
               tag_in.sh = SH_HIGH;
            end
            default: begin
               tag_in.tgt = TGT_NONE;
            end
         endcase
      end
   end

   assign prod_in = mul_a * mul_b;

   // shared shift-add accumulator
   always_comb begin
      unique case (tag_ff.sh)
         SH_NONE: addend = RSQ_W'(prod_ff);
         SH_MID:  addend = RSQ_W'(prod_ff) << MID_SH;
         SH_HIGH: addend = RSQ_W'(prod_ff) << HIGH_SH;
         default: addend = '0;
      endcase
      unique case (tag_ff.tgt)
         TGT_RAD:  add_base = RSQ_W'(rad_ff);
         TGT_RSQ:  add_base = rsq_ff;
         TGT_DIST: add_base = RSQ_W'(dist_ff);
         default:  add_base = '0;
      endcase
   end

   assign add_sum = add_base + addend;

   assign both_box = (ref_ff.kind == KIND_BOX) && (tst_ff.kind == KIND_BOX);
   assign dist_scaled = RSQ_W'({dist_ff, DIST_SH'(1'b0)});
   assign hit = both_box ? bb_ff : (dist_scaled < rsq_ff);

   always_comb begin
      ref_in = ref_ff;
      tst_in = tst_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      rad_in = rad_ff;
      rsq_in = rsq_ff;
      dist_in = dist_ff;
      bb_in = bb_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in = rsp_hit_ff;

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (tag_ff.tgt)
         TGT_RAD:  rad_in = add_sum[ERAD_W-1:0];
         TGT_RSQ:  rsq_in = add_sum;
         TGT_DIST: dist_in = add_sum[DIST_W-1:0];
         default:  rad_in = rad_ff;
      endcase

      if (busy_ff) begin
         if (step_ff == STEP_AXIS_X || step_ff == STEP_AXIS_Y || step_ff == STEP_AXIS_Z) begin
            bb_in = bb_ff & gap_neg;
         end
         if (step_ff == STEP_DONE) begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in = hit;
               busy_in = 1'b0;
            end
         end else begin
            step_in = step_ff + 4'd1;
         end
      end else if (req_accept) begin
         if (req_ch.payload.cmd == CMD_LOAD) begin
            ref_in = to_shape(req_ch.payload);
         end else begin
            tst_in = to_shape(req_ch.payload);
            busy_in = 1'b1;
            step_in = STEP_REF_RAD;
            rad_in = '0;
            rsq_in = '0;
            dist_in = '0;
            bb_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= '0;
         busy_ff <= 1'b0;
         step_ff <= STEP_REF_RAD;
         tag_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ref_ff <= ref_in;
         busy_ff <= busy_in;
         step_ff <= step_in;
         tag_ff <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tst_ff <= tst_in;
      prod_ff <= prod_in;
      rad_ff <= rad_in;
      rsq_ff <= rsq_in;
      dist_ff <= dist_in;
      bb_ff <= bb_in;
      rsp_hit_ff <= rsp_hit_in;
   end

   `SBOT_ASSERT_NEXT(a_load_stays_idle, req_accept && req_ch.payload.cmd == CMD_LOAD, !busy_ff, "load transaction started the sequencer")
   `SBOT_ASSERT_NEXT(a_test_starts, req_accept && req_ch.payload.cmd == CMD_TEST, busy_ff && step_ff == STEP_REF_RAD, "test transaction did not start the sequencer")
   `SBOT_ASSERT_SAME(a_result_from_done, $rose(rsp_valid_ff), $past(busy_ff) && $past(step_ff) == STEP_DONE, "result appeared outside the final step")

endmodule

`default_nettype wire

>>> tb/sphere_box_overlap_test_tb.sv
`default_nettype none

module sphere_box_overlap_test_tb;
   import sbot_pkg::*;

   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [15:0] UNIT_SCALE = 16'h0100;
   localparam int STALL_CYCLES = 300;
   localparam int DRAIN_LIMIT = 100000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sbot_req_if req_ch ();
   sbot_rsp_if rsp_ch ();

   sphere_box_overlap_test uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   sbot_req_type held_shape;
   bit pending_hits[$];
   int error_count = 0;
   bit sender_idles = 1'b1;
   bit receiver_idles = 1'b1;
   int unsigned stall_req_id = 0;
   int unsigned stall_seen_id = 0;
   int hold_left = 0;
   logic [31:0] shape_base [3];

   function automatic longint pos_of(sbot_req_type s, int a);
      case (a)
         0: return longint'($signed(s.pos_x));
         1: return longint'($signed(s.pos_y));
         default: return longint'($signed(s.pos_z));
      endcase
   endfunction

   function automatic longint size_of(sbot_req_type s, int a);
      case (a)
         0: return longint'({32'b0, s.size_x});
         1: return longint'({32'b0, s.size_y});
         default: return longint'({32'b0, s.size_z});
      endcase
   endfunction

   function automatic logic [127:0] scaled_radius(sbot_req_type s);
      logic [15:0] m;
      m = s.scale_x;
      if (s.scale_y > m) begin
         m = s.scale_y;
      end
      if (s.scale_z > m) begin
         m = s.scale_z;
      end
      return {96'b0, s.radius} * {112'b0, m};
   endfunction

   function automatic logic [127:0] magnitude(longint d);
      if (d < 0) begin
         return {64'b0, 64'(-d)};
      end
      return {64'b0, 64'(d)};
   endfunction

   function automatic bit spheres_hit(sbot_req_type a, sbot_req_type b);
      logic [127:0] dist_sum;
      logic [127:0] rsum;
      logic [127:0] m;
      dist_sum = '0;
      rsum = scaled_radius(a) + scaled_radius(b);
      for (int i = 0; i < 3; i++) begin
         m = magnitude(pos_of(a, i) - pos_of(b, i)) << 8;
         dist_sum = dist_sum + m * m;
      end
      return dist_sum < rsum * rsum;
   endfunction

   function automatic bit boxes_hit(sbot_req_type a, sbot_req_type b);
      longint lo1, hi1, lo2, hi2;
      for (int i = 0; i < 3; i++) begin
         lo1 = 2 * pos_of(a, i) - size_of(a, i);
         hi1 = 2 * pos_of(a, i) + size_of(a, i);
         lo2 = 2 * pos_of(b, i) - size_of(b, i);
         hi2 = 2 * pos_of(b, i) + size_of(b, i);
         if (lo2 >= hi1 || hi2 <= lo1) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic bit box_sphere_hit(sbot_req_type box, sbot_req_type sph);
      logic [127:0] dist_sum;
      logic [127:0] r;
      logic [127:0] m;
      longint c, lo, hi, q;
      dist_sum = '0;
      r = scaled_radius(sph);
      for (int i = 0; i < 3; i++) begin
         c = 2 * pos_of(sph, i);
         lo = 2 * pos_of(box, i) - size_of(box, i);
         hi = 2 * pos_of(box, i) + size_of(box, i);
         q = (c < lo) ? lo : ((c > hi) ? hi : c);
         m = magnitude(q - c) << 7;
         dist_sum = dist_sum + m * m;
      end
      return dist_sum < r * r;
   endfunction

   function automatic bit predict_hit(sbot_req_type held, sbot_req_type probe);
      if (probe.kind == KIND_SPHERE && held.kind == KIND_SPHERE) begin
         return spheres_hit(held, probe);
      end else if (probe.kind == KIND_BOX && held.kind == KIND_BOX) begin
         return boxes_hit(held, probe);
      end else if (held.kind == KIND_BOX) begin
         return box_sphere_hit(held, probe);
      end
      return box_sphere_hit(probe, held);
   endfunction

   function automatic sbot_req_type make_sphere(logic cmd, logic [31:0] px, logic [31:0] py,
                                                logic [31:0] pz, logic [31:0] r,
                                                logic [15:0] sx, logic [15:0] sy,
                                                logic [15:0] sz);
      sbot_req_type s;
      s = '0;
      s.cmd = cmd;
      s.kind = KIND_SPHERE;
      s.pos_x = px;
      s.pos_y = py;
      s.pos_z = pz;
      s.radius = r;
      s.scale_x = sx;
      s.scale_y = sy;
      s.scale_z = sz;
      return s;
   endfunction

   function automatic sbot_req_type make_box(logic cmd, logic [31:0] px, logic [31:0] py,
                                             logic [31:0] pz, logic [31:0] wx,
                                             logic [31:0] wy, logic [31:0] wz);
      sbot_req_type s;
      s = '0;
      s.cmd = cmd;
      s.kind = KIND_BOX;
      s.pos_x = px;
      s.pos_y = py;
      s.pos_z = pz;
      s.size_x = wx;
      s.size_y = wy;
      s.size_z = wz;
      return s;
   endfunction

   function automatic sbot_req_type noise_shape();
      sbot_req_type s;
      s.cmd = $urandom_range(1);
      s.kind = $urandom_range(1);
      s.pos_x = $urandom;
      s.pos_y = $urandom;
      s.pos_z = $urandom;
      s.size_x = $urandom;
      s.size_y = $urandom;
      s.size_z = $urandom;
      s.radius = $urandom;
      s.scale_x = $urandom;
      s.scale_y = $urandom;
      s.scale_z = $urandom;
      return s;
   endfunction

   // shape close to the current base so that hits and near misses are common
   function automatic sbot_req_type near_shape(logic cmd);
      sbot_req_type s;
      logic [31:0] p [3];
      logic [31:0] w [3];
      logic [15:0] sc [3];
      int off;
      bit grid;
      grid = ($urandom_range(3) == 0);
      for (int i = 0; i < 3; i++) begin
         off = int'($urandom_range(0, 20 * 65536)) - 10 * 65536;
         if (grid) begin
            off = off & ~32'h0000_ffff;
            w[i] = $urandom_range(0, 4) * 2 * ONE;
            sc[i] = UNIT_SCALE;
         end else begin
            w[i] = ($urandom_range(7) == 0) ? 32'd0 : $urandom_range(0, 8 * 65536);
            sc[i] = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(0, 512));
         end
         p[i] = shape_base[i] + off;
      end
      s.cmd = cmd;
      s.kind = $urandom_range(1);
      s.pos_x = p[0];
      s.pos_y = p[1];
      s.pos_z = p[2];
      s.size_x = w[0];
      s.size_y = w[1];
      s.size_z = w[2];
      s.radius = grid ? $urandom_range(0, 3) * ONE : $urandom_range(0, 6 * 65536);
      s.scale_x = sc[0];
      s.scale_y = sc[1];
      s.scale_z = sc[2];
      return s;
   endfunction

   task automatic send_shape(sbot_req_type item);
      while (sender_idles && $urandom_range(99) < 34) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= item;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      if (item.cmd == CMD_LOAD) begin
         held_shape = item;
      end else begin
         pending_hits.push_back(predict_hit(held_shape, item));
      end
   endtask

   task automatic test_reset_reference();
      send_shape(make_sphere(CMD_TEST, 0, 0, 0, 0, 0, 0, 0));
      send_shape(make_sphere(CMD_TEST, ONE, 0, 0, ONE, UNIT_SCALE, UNIT_SCALE, UNIT_SCALE));
      send_shape(make_box(CMD_TEST, 0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
   endtask

   task automatic test_sphere_sphere();
      send_shape(make_sphere(CMD_LOAD, ONE, -ONE, 0, 2 * ONE, 16'h0100, 16'h0080, 16'h0040));
      send_shape(make_sphere(CMD_TEST, ONE, -ONE, 0, 0, 0, 0, 0));
      send_shape(make_sphere(CMD_TEST, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                             32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff));
      send_shape(make_sphere(CMD_TEST, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
                             UNIT_SCALE, UNIT_SCALE, UNIT_SCALE));
      send_shape(make_sphere(CMD_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff));
      send_shape(make_sphere(CMD_TEST, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                             32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff));
      send_shape(make_sphere(CMD_TEST, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                             32'hffff_ffff, 0, 0, 0));
   endtask

   task automatic test_box_box();
      send_shape(make_box(CMD_LOAD, 0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
      // touching faces
      send_shape(make_box(CMD_TEST, 2 * ONE, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
      send_shape(make_box(CMD_TEST, 2 * ONE - 1, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
      send_shape(make_box(CMD_TEST, 0, 0, 0, 0, 0, 0));
      send_shape(make_box(CMD_TEST, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
      send_shape(make_box(CMD_LOAD, 0, 0, 0, 0, 0, 0));
      send_shape(make_box(CMD_TEST, 0, 0, 0, 0, 0, 0));
      send_shape(make_box(CMD_TEST, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
   endtask

   task automatic test_box_sphere();
      send_shape(make_box(CMD_LOAD, 0, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
      // centre on a face, zero radius
      send_shape(make_sphere(CMD_TEST, ONE, 0, 0, 0, UNIT_SCALE, UNIT_SCALE, UNIT_SCALE));
      send_shape(make_sphere(CMD_TEST, 3 * ONE, 0, 0, 2 * ONE, UNIT_SCALE, 0, 0));
      send_shape(make_sphere(CMD_TEST, 3 * ONE - 1, 0, 0, 2 * ONE, 0, 0, UNIT_SCALE));
      send_shape(make_sphere(CMD_LOAD, 0, 0, 0, ONE, 0, 0, UNIT_SCALE));
      send_shape(make_box(CMD_TEST, 2 * ONE, 0, 0, 2 * ONE, 2 * ONE, 2 * ONE));
      send_shape(make_box(CMD_TEST, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
   endtask

   task automatic test_unused_fields();
      sbot_req_type s;
      s = make_sphere(CMD_LOAD, ONE, 0, 0, ONE, UNIT_SCALE, UNIT_SCALE, UNIT_SCALE);
      s.size_x = $urandom;
      s.size_y = $urandom;
      s.size_z = $urandom;
      send_shape(s);
      s = make_box(CMD_TEST, 0, 0, 0, ONE, ONE, ONE);
      s.radius = $urandom;
      s.scale_x = $urandom;
      s.scale_y = $urandom;
      s.scale_z = $urandom;
      send_shape(s);
   endtask

   task automatic pick_base();
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(3))
            0: shape_base[i] = 32'h0;
            1: shape_base[i] = 32'h7ff0_0000;
            2: shape_base[i] = 32'h8010_0000;
            default: shape_base[i] = $urandom;
         endcase
      end
   endtask

   task automatic test_random_scenes(int count);
      int sent;
      int tests;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(9) == 0) begin
            send_shape(noise_shape());
            sent++;
         end else begin
            pick_base();
            send_shape(near_shape(CMD_LOAD));
            sent++;
            tests = $urandom_range(1, 6);
            for (int i = 0; i < tests; i++) begin
               send_shape(near_shape(CMD_TEST));
               sent++;
            end
         end
      end
   endtask

   task automatic test_backpressure();
      sender_idles = 1'b0;
      stall_req_id <= stall_req_id + 1;
      pick_base();
      send_shape(near_shape(CMD_LOAD));
      for (int i = 0; i < 40; i++) begin
         send_shape(near_shape(CMD_TEST));
      end
      sender_idles = 1'b1;
   endtask

   task automatic test_steady_stream();
      sender_idles = 1'b0;
      receiver_idles <= 1'b0;
      test_random_scenes(200);
      sender_idles = 1'b1;
      receiver_idles <= 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_hits.size() == 0) begin
               $error("unexpected transaction: hit %0b", rsp_ch.payload.hit);
               error_count++;
            end else if (pending_hits[0] !== rsp_ch.payload.hit) begin
               $error("hit mismatch: expected %0b, actual %0b", pending_hits[0],
                      rsp_ch.payload.hit);
               error_count++;
               void'(pending_hits.pop_front());
            end else begin
               void'(pending_hits.pop_front());
            end
         end
         if (stall_seen_id != stall_req_id) begin
            stall_seen_id = stall_req_id;
            hold_left = STALL_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (receiver_idles) begin
            rsp_ch.ready <= ($urandom_range(99) >= 34);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      int guard;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      held_shape = '0;
      for (int i = 0; i < 3; i++) begin
         shape_base[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_reference();
      test_sphere_sphere();
      test_box_box();
      test_box_sphere();
      test_unused_fields();
      test_random_scenes(700);
      test_backpressure();
      test_steady_stream();
      test_random_scenes(580);
      req_ch.valid <= 1'b0;
      guard = 0;
      while (pending_hits.size() > 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (30) @(posedge clock);
      if (pending_hits.size() > 0) begin
         $error("%0d expected transactions never arrived", pending_hits.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
